@@ hw/rtl/arc_pkg.sv @@
// Shared types, codes and the pair-slot function of the anti-Robinson criterion block.
// Used by anti_robinson_criterion, arc_walk and arc_accum; depends on nothing else.
package arc_pkg;

   localparam int ObjW    = 6;
   localparam int DistW   = 16;
   localparam int SumW    = 64;
   localparam int GapDiffW = ObjW + DistW;
   localparam int CsrW    = 7;
   localparam int ModeW   = 2;
   localparam int CmdW    = 2;
   localparam int SlotW   = 2 * ObjW;

   // Command codes carried in the request payload.
   localparam logic [CmdW-1:0] CMD_LOAD_DIST  = 2'd0;
   localparam logic [CmdW-1:0] CMD_LOAD_ORDER = 2'd1;
   localparam logic [CmdW-1:0] CMD_COMPUTE    = 2'd2;

   // Weight modes.
   localparam logic [ModeW-1:0] WM_COUNT = 2'd0;
   localparam logic [ModeW-1:0] WM_ABS   = 2'd1;
   localparam logic [ModeW-1:0] WM_GAP   = 2'd2;

   // Register indexes of the configuration port.
   localparam logic CSR_WEIGHT_MODE = 1'b0;
   localparam logic CSR_OBJECTS     = 1'b1;

   localparam logic [ModeW-1:0] WEIGHT_MODE_RESET = WM_COUNT;
   localparam logic [CsrW-1:0]  OBJECTS_RESET     = 7'd64;

   typedef struct packed {
      logic [CmdW-1:0]  cmd;
      logic [ObjW-1:0]  first_index;
      logic [ObjW-1:0]  second_index;
      logic [DistW-1:0] distance;
      logic [ObjW-1:0]  object_at_position;
   } req_type;

   typedef struct packed {
      logic [SumW-1:0] criterion;
      logic            saturated;
   } rsp_type;

   // One triple on its way from the walker to the scoring pipeline. The
   // distance to the j column arrives from the memory in the same cycle.
   typedef struct packed {
      logic             valid;
      logic             left;
      logic             zero;
      logic [ObjW-1:0]  obj_j;
      logic [ObjW-1:0]  obj_k;
      logic [DistW-1:0] dist_k;
   } tok_type;

   // Triangular slot of an unordered pair of distinct objects.
   function automatic logic [SlotW-1:0] pair_slot(input logic [ObjW-1:0] a,
                                                  input logic [ObjW-1:0] b);
      logic [ObjW-1:0]  hi;
      logic [ObjW-1:0]  lo;
      logic [SlotW-1:0] prod;
      hi   = (a > b) ? a : b;
      lo   = (a > b) ? b : a;
      prod = SlotW'(hi) * SlotW'(hi - ObjW'(1));
      return (prod >> 1) + SlotW'(lo);
   endfunction

endpackage

@@ hw/rtl/anti_robinson_criterion.sv @@
// Top level of the anti-Robinson events criterion block: ports, registers, stores.
// Depends on arc_pkg, arc_ram, arc_walk and arc_accum.
//
// Load transfers (cmd 0 writes one pair distance, cmd 1 one order entry) are
// taken one per cycle while no compute is running and produce no result. A
// compute transfer (cmd 2) walks every triple of a row position and two column
// positions on the same side of it among the first p = min(objects_in_use,
// MAX_OBJECTS) positions, one triple per cycle within a column, and returns one
// result with the 64-bit sum and a saturation flag; cmd 3 is dropped. The
// distance store and the order store are single-read-port RAMs with registered
// read data, and their read ports set the pace. req_stall is high for the whole
// compute. A finished result waits in an output register, and load transfers
// are taken meanwhile; a second compute may finish only once the earlier
// result has been taken. Both stores come up undefined and have no clearing
// pass, so every entry that a compute reads must be loaded first.
// Configuration writes belong in idle periods.
module anti_robinson_criterion #(
   parameter int MAX_OBJECTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  arc_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output arc_pkg::rsp_type          rsp_data,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [arc_pkg::CsrW-1:0]  csr_data
);

   import arc_pkg::*;

   localparam int PosW      = $clog2(MAX_OBJECTS);
   localparam int PairCount = MAX_OBJECTS * (MAX_OBJECTS - 1) / 2;
   localparam int SlotAddrW = $clog2(PairCount);

   logic [ModeW-1:0]    weight_mode_ff, weight_mode_in;
   logic [CsrW-1:0]     objects_ff, objects_in;
   logic                req_xfer;
   logic                start;
   logic                dist_we;
   logic [SlotAddrW-1:0] dist_wr_addr;
   logic [SlotAddrW-1:0] dist_rd_addr;
   logic [DistW-1:0]    dist_rd_data;
   logic                order_we;
   logic [PosW-1:0]     order_wr_addr;
   logic [PosW-1:0]     order_rd_addr;
   logic [ObjW-1:0]     order_rd_data;
   tok_type             tok;
   logic                walk_busy;
   logic                walk_done;
   logic                pipe_busy;
   logic                out_free;
   logic [SumW-1:0]     sum;
   logic                sum_sat;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   // Configuration registers. Both indexes exist, so every write lands.
   always_comb begin
      weight_mode_in = weight_mode_ff;
      objects_in     = objects_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WEIGHT_MODE: weight_mode_in = csr_data[ModeW-1:0];
            CSR_OBJECTS:     objects_in     = csr_data;
            default:         weight_mode_in = weight_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_mode_ff <= WEIGHT_MODE_RESET;
         objects_ff     <= OBJECTS_RESET;
      end else begin
         weight_mode_ff <= weight_mode_in;
         objects_ff     <= objects_in;
      end
   end

   // The request side is held off for the whole walk; loads only happen in idle.
   assign req_stall = walk_busy;
   assign req_xfer  = req_valid && !req_stall;
   assign start     = req_xfer && (req_data.cmd == CMD_COMPUTE);

   // A distance load is dropped when the two objects match or either one is
   // at or above the MAX_OBJECTS limit.
   assign dist_we = req_xfer && (req_data.cmd == CMD_LOAD_DIST)
                    && (req_data.first_index != req_data.second_index)
                    && (32'(req_data.first_index) < MAX_OBJECTS)
                    && (32'(req_data.second_index) < MAX_OBJECTS);
   assign dist_wr_addr = SlotAddrW'(pair_slot(req_data.first_index,
                                              req_data.second_index));

   assign order_we = req_xfer && (req_data.cmd == CMD_LOAD_ORDER)
                     && (32'(req_data.first_index) < MAX_OBJECTS);
   assign order_wr_addr = PosW'(req_data.first_index);

   arc_ram #(
      .Depth (PairCount),
      .Width (DistW)
   ) u_dist_store (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_wr_addr),
      .wr_data (req_data.distance),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd_data)
   );

   arc_ram #(
      .Depth (MAX_OBJECTS),
      .Width (ObjW)
   ) u_order_store (
      .clock   (clock),
      .wr_en   (order_we),
      .wr_addr (order_wr_addr),
      .wr_data (req_data.object_at_position),
      .rd_addr (order_rd_addr),
      .rd_data (order_rd_data)
   );

   arc_walk #(
      .MAX_OBJECTS (MAX_OBJECTS)
   ) u_walk (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .objects_in_use (objects_ff),
      .out_free       (out_free),
      .pipe_busy      (pipe_busy),
      .order_rd_addr  (order_rd_addr),
      .order_rd_data  (order_rd_data),
      .dist_rd_addr   (dist_rd_addr),
      .dist_rd_data   (dist_rd_data),
      .tok            (tok),
      .busy           (walk_busy),
      .done           (walk_done)
   );

   arc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .clear     (start),
      .mode      (weight_mode_ff),
      .tok       (tok),
      .dist_j    (dist_rd_data),
      .busy      (pipe_busy),
      .sum       (sum),
      .saturated (sum_sat)
   );

   // Output register. The walker only finishes when this slot is free or is
   // emptied by a transfer in the same cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (walk_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (walk_done) begin
         rsp_data_ff.criterion <= sum;
         rsp_data_ff.saturated <= sum_sat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A finished walk always shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      walk_done |=> rsp_valid)
      else $error("finished compute did not produce a result");

   // A walk must never finish over a result that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      walk_done |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // A saturated sum must read as all ones.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |-> (&rsp_data.criterion))
      else $error("saturated flag set on a sum that is not at its maximum");

   // Accepting a compute must close the request side in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("request side open right after a compute was taken");

endmodule

@@ hw/rtl/arc_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// Stands alone; used for the distance store and the order store.
module arc_ram #(
   parameter int  Depth = 64,
   parameter int  Width = 6,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/arc_walk.sv @@
// Triple walker: steps through rows, columns and partner columns and drives both memory reads.
// Depends on arc_pkg; feeds arc_accum.
module arc_walk #(
   parameter int  MAX_OBJECTS = 64,
   localparam int PosW      = $clog2(MAX_OBJECTS),
   localparam int PairCount = MAX_OBJECTS * (MAX_OBJECTS - 1) / 2,
   localparam int SlotAddrW = $clog2(PairCount)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [arc_pkg::CsrW-1:0] objects_in_use,
   input  logic                   out_free,
   input  logic                   pipe_busy,
   output logic [PosW-1:0]        order_rd_addr,
   input  logic [arc_pkg::ObjW-1:0] order_rd_data,
   output logic [SlotAddrW-1:0]   dist_rd_addr,
   input  logic [arc_pkg::DistW-1:0] dist_rd_data,
   output arc_pkg::tok_type       tok,
   output logic                   busy,
   output logic                   done
);

   import arc_pkg::*;

   localparam int CntW = $clog2(MAX_OBJECTS + 1);

   typedef enum logic [8:0] {
      W_IDLE     = 9'b000000001,
      W_ROW_RD   = 9'b000000010,
      W_ROW_CAP  = 9'b000000100,
      W_COL_RD   = 9'b000001000,
      W_COL_OBJ  = 9'b000010000,
      W_COL_DIST = 9'b000100000,
      W_STREAM   = 9'b001000000,
      W_DRAIN    = 9'b010000000,
      W_FINISH   = 9'b100000000
   } walk_state_type;

   walk_state_type   state_ff, state_in;
   logic [CntW-1:0]  p_ff, p_in;
   logic [CntW-1:0]  i_ff, i_in;
   logic [CntW-1:0]  k_ff, k_in;
   logic [CntW-1:0]  j_ff, j_in;
   logic [CntW-1:0]  j_start;
   logic [ObjW-1:0]  oi_ff, oi_in;
   logic [ObjW-1:0]  ok_ff, ok_in;
   logic [DistW-1:0] dk_ff, dk_in;
   logic             dz_ff, dz_in;
   logic             left_ff, left_in;
   logic             a_valid_ff, a_valid_in;
   logic             pair_zero;
   tok_type          tok_ff, tok_in;

   // The pair of the row object and whatever the order store just returned.
   assign pair_zero = (oi_ff == order_rd_data)
                      || (32'(oi_ff) >= MAX_OBJECTS)
                      || (32'(order_rd_data) >= MAX_OBJECTS);
   assign dist_rd_addr = SlotAddrW'(pair_slot(oi_ff, order_rd_data));
   assign j_start = (k_ff < i_ff) ? '0 : i_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      oi_in         = oi_ff;
      ok_in         = ok_ff;
      dk_in         = dk_ff;
      dz_in         = dz_ff;
      left_in       = left_ff;
      a_valid_in    = 1'b0;
      order_rd_addr = i_ff[PosW-1:0];
      done          = 1'b0;
      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               if (32'(objects_in_use) > MAX_OBJECTS) begin
                  p_in = CntW'(MAX_OBJECTS);
               end else begin
                  p_in = CntW'(objects_in_use);
               end
               i_in     = '0;
               state_in = W_ROW_RD;
            end
         end
         W_ROW_RD: begin
            if (i_ff == p_ff) begin
               state_in = W_DRAIN;
            end else begin
               order_rd_addr = i_ff[PosW-1:0];
               state_in      = W_ROW_CAP;
            end
         end
         W_ROW_CAP: begin
            oi_in    = order_rd_data;
            k_in     = '0;
            state_in = W_COL_RD;
         end
         W_COL_RD: begin
            if (k_ff == p_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = W_ROW_RD;
            end else if (k_ff == i_ff || j_start >= k_ff) begin
               k_in = k_ff + 1'b1;
            end else begin
               order_rd_addr = k_ff[PosW-1:0];
               j_in          = j_start;
               left_in       = (k_ff < i_ff);
               state_in      = W_COL_OBJ;
            end
         end
         W_COL_OBJ: begin
            ok_in    = order_rd_data;
            dz_in    = pair_zero;
            state_in = W_COL_DIST;
         end
         W_COL_DIST: begin
            dk_in    = dz_ff ? '0 : dist_rd_data;
            state_in = W_STREAM;
         end
         W_STREAM: begin
            order_rd_addr = j_ff[PosW-1:0];
            a_valid_in    = 1'b1;
            if (j_ff + 1'b1 == k_ff) begin
               k_in     = k_ff + 1'b1;
               state_in = W_COL_RD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         W_DRAIN: begin
            if (!a_valid_ff && !tok_ff.valid && !pipe_busy) begin
               state_in = W_FINISH;
            end
         end
         W_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   // Partner column whose object was read last cycle; its distance read goes out now.
   always_comb begin
      tok_in        = tok_ff;
      tok_in.valid  = a_valid_ff;
      tok_in.left   = left_ff;
      tok_in.zero   = pair_zero;
      tok_in.obj_j  = order_rd_data;
      tok_in.obj_k  = ok_ff;
      tok_in.dist_k = dk_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= W_IDLE;
         a_valid_ff <= 1'b0;
         tok_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         a_valid_ff <= a_valid_in;
         tok_ff     <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      j_ff          <= j_in;
      oi_ff         <= oi_in;
      ok_ff         <= ok_in;
      dk_ff         <= dk_in;
      dz_ff         <= dz_in;
      left_ff       <= left_in;
   end

   assign tok  = tok_ff;
   assign busy = (state_ff != W_IDLE);

endmodule

@@ hw/rtl/arc_accum.sv @@
// Scoring pipeline: violation test, weight and saturating 64-bit sum.
// Depends on arc_pkg; takes triples from arc_walk.
module arc_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic [arc_pkg::ModeW-1:0] mode,
   input  arc_pkg::tok_type          tok,
   input  logic [arc_pkg::DistW-1:0] dist_j,
   output logic                      busy,
   output logic [arc_pkg::SumW-1:0]  sum,
   output logic                      saturated
);

   import arc_pkg::*;

   logic [DistW-1:0]    dj;
   logic                viol;
   logic                c_valid_ff;
   logic [DistW-1:0]    c_diff_ff;
   logic [ObjW-1:0]     c_gap_ff;
   logic                d_valid_ff;
   logic [GapDiffW-1:0] d_weight_ff, d_weight_in;
   logic [SumW-1:0]     sum_ff;
   logic                sat_ff;
   logic [SumW:0]       sum_wide;

   assign dj   = tok.zero ? '0 : dist_j;
   assign viol = tok.left ? (dj < tok.dist_k) : (dj > tok.dist_k);

   always_comb begin
      unique case (mode)
         WM_COUNT: d_weight_in = GapDiffW'(1);
         WM_ABS:   d_weight_in = GapDiffW'(c_diff_ff);
         WM_GAP:   d_weight_in = GapDiffW'(c_gap_ff) * GapDiffW'(c_diff_ff);
         default:  d_weight_in = '0;
      endcase
   end

   assign sum_wide = {1'b0, sum_ff} + (SumW + 1)'(d_weight_ff);

   always_ff @(posedge clock) begin
      c_diff_ff   <= (dj > tok.dist_k) ? dj - tok.dist_k : tok.dist_k - dj;
      c_gap_ff    <= (tok.obj_j > tok.obj_k) ? tok.obj_j - tok.obj_k
                                             : tok.obj_k - tok.obj_j;
      d_weight_ff <= d_weight_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         sum_ff     <= '0;
         sat_ff     <= 1'b0;
      end else begin
         c_valid_ff <= tok.valid && viol;
         d_valid_ff <= c_valid_ff;
         if (clear) begin
            sum_ff <= '0;
            sat_ff <= 1'b0;
         end else if (d_valid_ff) begin
            if (sum_wide[SumW]) begin
               sum_ff <= '1;
               sat_ff <= 1'b1;
            end else begin
               sum_ff <= sum_wide[SumW-1:0];
            end
         end
      end
   end

   assign busy      = c_valid_ff || d_valid_ff;
   assign sum       = sum_ff;
   assign saturated = sat_ff;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the anti-Robinson criterion block: loads, computes, register phases.
// Depends on arc_pkg and anti_robinson_criterion; a scoreboard class inside predicts every sum.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import arc_pkg::*;

   localparam int MAX_OBJ = 64;
   localparam int PAIR_COUNT = MAX_OBJ * (MAX_OBJ - 1) / 2;
   localparam int HALF_PERIOD = 6;
   // Loads produce no result, so after the last result the block may still be
   // finishing a load or draining; this many cycles covers that.
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES = 3000;
   localparam int ITEM_TARGET = 1300;
   localparam int PHASE_ITEMS = 120;
   localparam int TINY_PHASE_ITEMS = 40;
   // The run holds two full 64-object computes; the limit covers the whole run.
   localparam int LIMIT_NS = 30_000_000;

   // Codes the package leaves unnamed.
   localparam logic [CmdW-1:0]  CMD_UNUSED = 2'd3;
   localparam logic [ModeW-1:0] WM_UNUSED  = 2'd3;

   // The scoreboard keeps its own copy of both stores and both registers.
   // Every accepted load that the block does not drop updates that copy; a
   // compute transfer pushes the predicted sum, which the result monitor pops in order.
   class arc_scoreboard;
      bit [DistW-1:0] distance_mem [PAIR_COUNT];
      bit [ObjW-1:0]  order_mem [MAX_OBJ];
      bit [ModeW-1:0] weight_mode;
      bit [CsrW-1:0]  objects_in_use;
      rsp_type        expected_results [$];
      int unsigned    results_checked;
      int unsigned    failures;

      function new();
         weight_mode    = WEIGHT_MODE_RESET;
         objects_in_use = OBJECTS_RESET;
      endfunction

      // Triangular slot of an unordered pair of distinct objects.
      static function int unsigned pair_index(int unsigned a, int unsigned b);
         int unsigned hi;
         int unsigned lo;
         hi = (a > b) ? a : b;
         lo = (a > b) ? b : a;
         return hi * (hi - 1) / 2 + lo;
      endfunction

      // An object is at distance zero from itself.
      function int unsigned distance_between(int unsigned a, int unsigned b);
         if (a == b) return 0;
         return distance_mem[pair_index(a, b)];
      endfunction

      function void set_register(logic reg_index, logic [CsrW-1:0] value);
         if (reg_index == CSR_WEIGHT_MODE) weight_mode = value[ModeW-1:0];
         else objects_in_use = value;
      endfunction

      function void note_request(req_type r);
         int unsigned   p;
         int unsigned   oi;
         int unsigned   oj;
         int unsigned   ok;
         int unsigned   dj;
         int unsigned   dk;
         bit [SumW-1:0] sum;
         bit [SumW-1:0] diff;
         bit [SumW-1:0] gap;
         bit [SumW-1:0] w;
         bit            sat;
         bit            viol;
         rsp_type       res;
         case (r.cmd)
            CMD_LOAD_DIST: begin
               if (r.first_index != r.second_index)
                  distance_mem[pair_index(r.first_index, r.second_index)] = r.distance;
            end
            CMD_LOAD_ORDER: begin
               order_mem[r.first_index] = r.object_at_position;
            end
            CMD_COMPUTE: begin
               p   = (objects_in_use > MAX_OBJ) ? MAX_OBJ : objects_in_use;
               sum = '0;
               sat = 1'b0;
               for (int i = 0; i < p; i++) begin
                  oi = order_mem[i];
                  for (int k = 0; k < p; k++) begin
                     if (k == i) continue;
                     ok = order_mem[k];
                     dk = distance_between(oi, ok);
                     for (int j = 0; j < k; j++) begin
                        // Both columns must sit on the same side of the row.
                        if (j == i || ((j < i) != (k < i))) continue;
                        oj = order_mem[j];
                        dj = distance_between(oi, oj);
                        // Left of the diagonal distances must not grow toward
                        // it; right of it they must not shrink away from it.
                        viol = (k < i) ? (dj < dk) : (dj > dk);
                        if (!viol) continue;
                        diff = (dj > dk) ? SumW'(dj - dk) : SumW'(dk - dj);
                        gap  = (oj > ok) ? SumW'(oj - ok) : SumW'(ok - oj);
                        case (weight_mode)
                           WM_COUNT: w = 1;
                           WM_ABS:   w = diff;
                           WM_GAP:   w = gap * diff;
                           default:  w = '0;
                        endcase
                        if (sum > ~w) begin
                           sum = '1;
                           sat = 1'b1;
                        end else begin
                           sum = sum + w;
                        end
                     end
                  end
               end
               res.criterion = sum;
               res.saturated = sat;
               expected_results.push_back(res);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $error("result with no compute outstanding: criterion %0d", got.criterion);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         results_checked++;
         if (got.criterion !== want.criterion) begin
            $error("criterion: expected %0d, got %0d", want.criterion, got.criterion);
            failures++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            failures++;
         end
      endfunction
   endclass

   // All block inputs start at known values.
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write = 1'b0;
   logic             csr_index = 1'b0;
   logic [CsrW-1:0]  csr_data  = '0;

   arc_scoreboard sb;

   // What the stimulus knows it has loaded so far. A compute may only be
   // sent once every order position and every pair it reads is loaded.
   bit [ObjW-1:0] planned_order [MAX_OBJ];
   bit            order_loaded [MAX_OBJ];
   bit            pair_loaded [PAIR_COUNT];

   // Objects are drawn from a window of the object space; a narrow window
   // keeps the number of pairs small when all 64 positions are scored.
   bit [ObjW-1:0] pool_base = '0;
   int unsigned   pool_size = MAX_OBJ;

   int unsigned burst_left;
   int unsigned transfers_sent;
   int unsigned computes_sent;
   int unsigned settings_used;
   bit          hold_request = 1'b0;

   anti_robinson_criterion #(.MAX_OBJECTS(MAX_OBJ)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #(HALF_PERIOD) clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("tb: FAIL");
      $finish;
   end

   function automatic req_type make_req(logic [CmdW-1:0] cmd, logic [ObjW-1:0] a,
                                        logic [ObjW-1:0] b, logic [DistW-1:0] d,
                                        logic [ObjW-1:0] obj);
      req_type r;
      r.cmd                = cmd;
      r.first_index        = a;
      r.second_index       = b;
      r.distance           = d;
      r.object_at_position = obj;
      return r;
   endfunction

   function automatic logic [ObjW-1:0] pick_object();
      return pool_base + ObjW'($urandom_range(0, pool_size - 1));
   endfunction

   // Small values and values near full scale make ties and large
   // differences common; the rest are uniform.
   function automatic logic [DistW-1:0] random_distance();
      case ($urandom_range(0, 3))
         0: return DistW'($urandom_range(0, 3));
         1: return ~DistW'($urandom_range(0, 3));
         default: return DistW'($urandom);
      endcase
   endfunction

   // Offers one transfer and holds it until the block takes it. The sender
   // runs in bursts; between bursts it idles for a random gap, and a zero gap
   // simply joins two bursts into a longer stretch without idling.
   task automatic send(input req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(item);
      transfers_sent++;
      if (item.cmd == CMD_LOAD_DIST && item.first_index != item.second_index) begin
         pair_loaded[arc_scoreboard::pair_index(item.first_index, item.second_index)] = 1'b1;
      end else if (item.cmd == CMD_LOAD_ORDER) begin
         order_loaded[item.first_index]  = 1'b1;
         planned_order[item.first_index] = item.object_at_position;
      end else if (item.cmd == CMD_COMPUTE) begin
         computes_sent++;
      end
   endtask

   // Waits until every expected result has arrived and the block has had
   // time to finish any trailing load.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers while the block is idle. Bits above the weight
   // mode field are random, since the block keeps only the low two.
   task automatic apply_setting(input logic [ModeW-1:0] mode, input logic [CsrW-1:0] objects);
      logic [CsrW-1:0] mode_word;
      wait_idle();
      mode_word = {(CsrW - ModeW)'($urandom), mode};
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_WEIGHT_MODE;
      csr_data  <= mode_word;
      @(negedge clock);
      csr_index <= CSR_OBJECTS;
      csr_data  <= objects;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.set_register(CSR_WEIGHT_MODE, mode_word);
      sb.set_register(CSR_OBJECTS, objects);
      settings_used++;
   endtask

   // One well-formed sequence: place objects on the scored positions, mix in
   // some noise, load every pair the compute will read, then compute. Noise
   // comes before the pair loads so that it can never leave a read pair
   // unloaded. Some sequences are abandoned before the compute.
   task automatic run_sequence(input int unsigned p_eff, input bit do_compute);
      int unsigned oa;
      int unsigned ob;
      for (int pos = 0; pos < p_eff; pos++) begin
         if (!order_loaded[pos] || $urandom_range(0, 2) == 0)
            send(make_req(CMD_LOAD_ORDER, ObjW'(pos), ObjW'($urandom), DistW'($urandom),
                          pick_object()));
      end
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 3))
            0: send(make_req(CMD_UNUSED, ObjW'($urandom), ObjW'($urandom),
                             DistW'($urandom), ObjW'($urandom)));
            1: begin
               // A pair of an object with itself is dropped by the block.
               oa = $urandom_range(0, MAX_OBJ - 1);
               send(make_req(CMD_LOAD_DIST, ObjW'(oa), ObjW'(oa), random_distance(),
                             ObjW'($urandom)));
            end
            2: send(make_req(CMD_LOAD_DIST, pick_object(), pick_object(),
                             random_distance(), ObjW'($urandom)));
            default: send(make_req(CMD_LOAD_ORDER, ObjW'($urandom), ObjW'($urandom),
                                   DistW'($urandom), pick_object()));
         endcase
      end
      for (int a = 0; a < p_eff; a++) begin
         for (int b = a + 1; b < p_eff; b++) begin
            oa = planned_order[a];
            ob = planned_order[b];
            if (oa != ob && (!pair_loaded[arc_scoreboard::pair_index(oa, ob)] ||
                             $urandom_range(0, p_eff) == 0)) begin
               if ($urandom_range(0, 1) == 0)
                  send(make_req(CMD_LOAD_DIST, ObjW'(oa), ObjW'(ob), random_distance(),
                                ObjW'($urandom)));
               else
                  send(make_req(CMD_LOAD_DIST, ObjW'(ob), ObjW'(oa), random_distance(),
                                ObjW'($urandom)));
            end
         end
      end
      if (do_compute)
         send(make_req(CMD_COMPUTE, ObjW'($urandom), ObjW'($urandom), DistW'($urandom),
                       ObjW'($urandom)));
   endtask

   // One register setting, then sequences until the phase has sent its
   // share of transfers. The first sequence of a phase always computes.
   task automatic run_phase(input logic [ModeW-1:0] mode, input logic [CsrW-1:0] objects,
                            input int unsigned quota, input bit pressure);
      int unsigned p_eff;
      int unsigned start;
      int unsigned seq;
      apply_setting(mode, objects);
      p_eff = (objects > MAX_OBJ) ? MAX_OBJ : objects;
      start = transfers_sent;
      seq   = 0;
      while (transfers_sent - start < quota) begin
         // From the second sequence on, the receiver stops taking results
         // for a long stretch, so the next compute backs up the input.
         if (pressure && seq == 1) hold_request = 1'b1;
         run_sequence(p_eff, seq == 0 || $urandom_range(0, 7) != 0);
         seq++;
      end
   endtask

   // The receiver changes its stall style every stretch: never, rarely,
   // mostly, or a regular on-off pattern. Once asked, it stalls without a
   // break, and it does so only once.
   initial begin
      int unsigned style;
      int unsigned stretch;
      bit          held;
      held = 1'b0;
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         style   = $urandom_range(0, 3);
         stretch = $urandom_range(10, 200);
         for (int n = 0; n < stretch; n++) begin
            @(negedge clock);
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= n[2];
            endcase
         end
      end
   end

   // Results are sampled at the rising edge at which the transfer happens.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with three scored positions and the index-weighted
      // mode, so that the largest weights show up at once. The first order
      // holds object 0 twice; the distance of an object to itself reads zero.
      apply_setting(WM_GAP, 7'd3);
      send(make_req(CMD_LOAD_ORDER, 6'd0, 6'd0, 16'h0000, 6'd0));
      send(make_req(CMD_LOAD_ORDER, 6'd1, 6'd63, 16'hFFFF, 6'd63));
      send(make_req(CMD_LOAD_ORDER, 6'd2, 6'd0, 16'h0000, 6'd0));
      send(make_req(CMD_LOAD_ORDER, 6'd63, 6'd0, 16'h0000, 6'd63));
      send(make_req(CMD_LOAD_DIST, 6'd0, 6'd63, 16'hFFFF, 6'd0));
      // A pair of an object with itself and the unused command are dropped.
      send(make_req(CMD_LOAD_DIST, 6'd9, 6'd9, 16'h1234, 6'd0));
      send(make_req(CMD_UNUSED, 6'd63, 6'd63, 16'hFFFF, 6'd63));
      send(make_req(CMD_COMPUTE, 6'd0, 6'd0, 16'h0000, 6'd0));
      // Swap in object 62; its pairs are loaded with the indexes reversed.
      send(make_req(CMD_LOAD_ORDER, 6'd1, 6'd0, 16'h0000, 6'd62));
      send(make_req(CMD_LOAD_DIST, 6'd62, 6'd0, 16'h0100, 6'd0));
      send(make_req(CMD_LOAD_DIST, 6'd63, 6'd62, 16'hFFFF, 6'd63));
      send(make_req(CMD_COMPUTE, 6'd63, 6'd63, 16'hFFFF, 6'd63));
      // Three distinct objects, with a violation on each side of the diagonal.
      send(make_req(CMD_LOAD_ORDER, 6'd2, 6'd0, 16'h0000, 6'd63));
      send(make_req(CMD_LOAD_DIST, 6'd63, 6'd0, 16'h0001, 6'd0));
      send(make_req(CMD_COMPUTE, 6'd0, 6'd63, 16'h0000, 6'd0));

      // Register extremes: fewer than three positions, the unused weight
      // mode, a count above the object limit, and the full 64 objects.
      run_phase(WM_COUNT, 7'd0, TINY_PHASE_ITEMS, 1'b0);
      run_phase(WM_ABS, 7'd1, TINY_PHASE_ITEMS, 1'b0);
      run_phase(WM_GAP, 7'd2, TINY_PHASE_ITEMS, 1'b0);
      run_phase(WM_UNUSED, 7'd7, PHASE_ITEMS, 1'b0);
      run_phase(WM_ABS, CsrW'($urandom_range(4, 10)), PHASE_ITEMS, 1'b1);
      pool_base = ObjW'($urandom);
      pool_size = 5;
      run_phase(WM_COUNT, 7'd127, 1, 1'b0);
      pool_base = '0;
      pool_size = MAX_OBJ;
      run_phase(WM_GAP, CsrW'($urandom_range(3, 10)), PHASE_ITEMS, 1'b0);
      pool_base = ObjW'($urandom);
      pool_size = 8;
      run_phase(WM_GAP, 7'd64, 1, 1'b0);
      pool_base = '0;
      pool_size = MAX_OBJ;
      run_phase(WM_COUNT, 7'd3, PHASE_ITEMS, 1'b0);

      // Random phases with small orders keep each compute short.
      while (transfers_sent < ITEM_TARGET) begin
         run_phase(ModeW'($urandom_range(0, 3)),
                   ($urandom_range(0, 5) == 0) ? CsrW'($urandom_range(0, 2))
                                               : CsrW'($urandom_range(3, 10)),
                   PHASE_ITEMS, 1'b0);
      end
      wait_idle();

      $display("Run covered %0d input transfers, %0d computes, under %0d register settings.",
               transfers_sent, computes_sent, settings_used);
      $display("Compared %0d results and found %0d failures.",
               sb.results_checked, sb.failures);
      if (sb.failures == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
